@@ hw/rtl/tia_pkg.sv @@
// tia_pkg: opcodes, type codes, queue entry type and helper functions
// for the typed integer alu; no dependencies
package tia_pkg;

    localparam int DataW = 64;
    localparam int TypeW = 3;
    localparam int OpW   = 4;
    localparam int QueueDepthDefault = 4;

    localparam logic [OpW-1:0] OP_ADD  = 4'd0;
    localparam logic [OpW-1:0] OP_SUB  = 4'd1;
    localparam logic [OpW-1:0] OP_MUL  = 4'd2;
    localparam logic [OpW-1:0] OP_DIV  = 4'd3;
    localparam logic [OpW-1:0] OP_MOD  = 4'd4;
    localparam logic [OpW-1:0] OP_AND  = 4'd5;
    localparam logic [OpW-1:0] OP_OR   = 4'd6;
    localparam logic [OpW-1:0] OP_XOR  = 4'd7;
    localparam logic [OpW-1:0] OP_SHL  = 4'd8;
    localparam logic [OpW-1:0] OP_SHR  = 4'd9;
    localparam logic [OpW-1:0] OP_MAX  = 4'd10;
    localparam logic [OpW-1:0] OP_MIN  = 4'd11;
    localparam logic [OpW-1:0] OP_NEG  = 4'd12;
    localparam logic [OpW-1:0] OP_ABS  = 4'd13;
    localparam logic [OpW-1:0] OP_SIGN = 4'd14;
    localparam logic [OpW-1:0] OP_CAST = 4'd15;

    localparam logic [TypeW-1:0] TYPE_INT64 = 3'd3;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // classified request passed from front to back
    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic             a_neg;
        logic             b_neg;
        logic             both_uns;
        logic [TypeW-1:0] rtype;
    } tia_entry_t;

    function automatic logic [DataW-1:0] narrow(input logic [DataW-1:0] v,
                                                input logic [TypeW-1:0] t);
        logic [DataW-1:0] r;
        r = v;
        case (t[1:0])
            2'd0: r = t[2] ? {56'd0, v[7:0] & BYTE_MASK} : {{56{v[7]}}, v[7:0]};
            2'd1: r = t[2] ? {48'd0, v[15:0]} : {{48{v[15]}}, v[15:0]};
            2'd2: r = t[2] ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [TypeW-1:0] promote(input logic [TypeW-1:0] ta,
                                                 input logic [TypeW-1:0] tb);
        logic [1:0] w;
        logic [TypeW-1:0] r;
        w = (ta[1:0] >= tb[1:0]) ? ta[1:0] : tb[1:0];
        if (ta[2] == tb[2])
            r = {ta[2], w};
        else
            r = (w == 2'd3) ? TYPE_INT64 : {1'b0, w + 2'd1};
        return r;
    endfunction

endpackage

@@ hw/rtl/tia_front.sv @@
// tia_front: accepts requests, narrows operands and works out result type
// depends on tia_pkg
module tia_front
    import tia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [OpW-1:0]   req_type,
    input  logic [DataW-1:0] a_value,
    input  logic [TypeW-1:0] a_type,
    input  logic [DataW-1:0] b_value,
    input  logic [TypeW-1:0] b_type,
    input  logic             in_valid,
    output logic             in_ready,
    output tia_entry_t       ent,
    output logic             ent_valid,
    input  logic             ent_ready
);

    tia_entry_t ent_reg, ent_next;
    logic       valid_reg;
    logic [DataW-1:0] a_n, b_n;

    assign in_ready  = !valid_reg || ent_ready;
    assign ent       = ent_reg;
    assign ent_valid = valid_reg;

    // classify request
    always_comb
    begin
        a_n = narrow(a_value, a_type);
        b_n = narrow(b_value, b_type);
        ent_next.op       = req_type;
        ent_next.a        = a_n;
        ent_next.b        = b_n;
        ent_next.a_neg    = !a_type[2] && a_n[DataW-1];
        ent_next.b_neg    = !b_type[2] && b_n[DataW-1];
        ent_next.both_uns = a_type[2] && b_type[2];
        case (req_type)
            OP_NEG, OP_ABS: ent_next.rtype = a_type;
            OP_SIGN:        ent_next.rtype = TYPE_INT64;
            OP_CAST:        ent_next.rtype = b_type;
            default:        ent_next.rtype = promote(a_type, b_type);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            ent_reg <= ent_next;
    end

endmodule

@@ hw/rtl/tia_queue.sv @@
// tia_queue: small fifo between front and back
// depends on tia_pkg
module tia_queue
    import tia_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tia_entry_t wr_data,
    input  logic       wr_valid,
    output logic       wr_ready,
    output tia_entry_t rd_data,
    output logic       rd_valid,
    input  logic       rd_ready
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    tia_entry_t mem [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = cnt_reg != (AW+1)'(Depth);
    assign rd_valid = cnt_reg != '0;
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

endmodule

@@ hw/rtl/tia_back.sv @@
// tia_back: execution pipeline; pipelined multiplier, pipelined radix-2
// divider (one stage per quotient bit), output register; uses tia_pkg
module tia_back
    import tia_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tia_entry_t       ent,
    input  logic             ent_valid,
    output logic             ent_ready,
    output logic [DataW-1:0] result_value,
    output logic [TypeW-1:0] result_type,
    output logic             status,
    output logic             out_valid,
    input  logic             out_ready
);

    // pipeline depth: 1 prep + 64 divide stages + 1 finish
    localparam int NStg = DataW + 2;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [TypeW-1:0] rtype;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic [DataW-1:0] res;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
        logic [DataW-1:0] dvs;
        logic [DataW-1:0] m0;
        logic [DataW-1:0] m1;
        logic [DataW-1:0] m2;
    } stg_t;

    stg_t stg_reg [NStg];
    logic stg_v_reg [NStg];
    stg_t s0_next;
    logic adv;
    logic [DataW-1:0] out_val_reg;
    logic [TypeW-1:0] out_type_reg;
    logic out_st_reg, out_v_reg;
    logic [DataW-1:0] fin_v;
    logic [DataW-1:0] fill, shr_v, shl_v;
    logic take_a, a_ge_b, a_le_b, a_lt_u;
    logic big_sh;
    logic [DataW-1:0] ua, ub;

    // whole pipe advances unless the output register is blocked
    assign adv       = !out_v_reg || out_ready;
    assign ent_ready = adv;

    // first stage: simple ops and divider/multiplier prep
    always_comb
    begin
        fill   = ent.a[DataW-1] ? '1 : '0;
        big_sh = ent.b[DataW-1:6] != '0;
        shl_v  = big_sh ? '0 : ent.a << ent.b[5:0];
        shr_v  = big_sh ? fill : DataW'($signed(ent.a) >>> ent.b[5:0]);
        a_lt_u = ent.a < ent.b;
        if (ent.a_neg != ent.b_neg)
        begin
            a_ge_b = ent.b_neg;
            a_le_b = ent.a_neg;
        end
        else
        begin
            a_ge_b = !a_lt_u;
            a_le_b = a_lt_u || ent.a == ent.b;
        end
        take_a = (ent.op == OP_MAX) ? a_ge_b : a_le_b;
        ua = (!ent.both_uns && ent.a[DataW-1]) ? -ent.a : ent.a;
        ub = (!ent.both_uns && ent.b[DataW-1]) ? -ent.b : ent.b;
        s0_next       = '0;
        s0_next.op    = ent.op;
        s0_next.rtype = ent.rtype;
        s0_next.dz    = ent.b == '0;
        s0_next.neg_q = !ent.both_uns && (ent.a[DataW-1] != ent.b[DataW-1]);
        s0_next.neg_r = !ent.both_uns && ent.a[DataW-1];
        s0_next.quo   = ua;
        s0_next.dvs   = ub;
        s0_next.m0    = {32'd0, ent.a[31:0]} * {32'd0, ent.b[31:0]};
        s0_next.m1    = {32'd0, ent.a[63:32]} * {32'd0, ent.b[31:0]};
        s0_next.m2    = {32'd0, ent.a[31:0]} * {32'd0, ent.b[63:32]};
        case (ent.op)
            OP_ADD:  s0_next.res = ent.a + ent.b;
            OP_SUB:  s0_next.res = ent.a - ent.b;
            OP_AND:  s0_next.res = ent.a & ent.b;
            OP_OR:   s0_next.res = ent.a | ent.b;
            OP_XOR:  s0_next.res = ent.a ^ ent.b;
            OP_SHL:  s0_next.res = shl_v;
            OP_SHR:  s0_next.res = shr_v;
            OP_MAX, OP_MIN: s0_next.res = take_a ? ent.a : ent.b;
            OP_NEG:  s0_next.res = -ent.a;
            OP_ABS:  s0_next.res = ent.a_neg ? -ent.a : ent.a;
            OP_SIGN: s0_next.res = ent.a_neg ? '1 : ((ent.a != '0) ? 64'd1 : 64'd0);
            default: s0_next.res = ent.a;
        endcase
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NStg; i++)
                stg_v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            stg_v_reg[0] <= ent_valid;
            for (int i = 1; i < NStg; i++)
                stg_v_reg[i] <= stg_v_reg[i-1];
        end
    end

    // pipeline registers: stage 0 takes request, stages 1..64 divide one bit
    always_ff @(posedge clk)
    begin
        logic [DataW:0] tr;
        if (adv)
        begin
            stg_reg[0].op    <= s0_next.op;
            stg_reg[0].rtype <= s0_next.rtype;
            stg_reg[0].neg_q <= s0_next.neg_q;
            stg_reg[0].neg_r <= s0_next.neg_r;
            stg_reg[0].dz    <= s0_next.dz;
            stg_reg[0].res   <= s0_next.res;
            stg_reg[0].rem   <= s0_next.rem;
            stg_reg[0].quo   <= s0_next.quo;
            stg_reg[0].dvs   <= s0_next.dvs;
            stg_reg[0].m0    <= s0_next.m0;
            stg_reg[0].m1    <= s0_next.m1;
            stg_reg[0].m2    <= s0_next.m2;
            for (int i = 1; i < NStg; i++)
            begin
                tr = {stg_reg[i-1].rem, stg_reg[i-1].quo[DataW-1]} -
                     {1'b0, stg_reg[i-1].dvs};
                stg_reg[i].op    <= stg_reg[i-1].op;
                stg_reg[i].rtype <= stg_reg[i-1].rtype;
                stg_reg[i].neg_q <= stg_reg[i-1].neg_q;
                stg_reg[i].neg_r <= stg_reg[i-1].neg_r;
                stg_reg[i].dz    <= stg_reg[i-1].dz;
                stg_reg[i].dvs   <= stg_reg[i-1].dvs;
                stg_reg[i].m0    <= stg_reg[i-1].m0;
                stg_reg[i].m1    <= stg_reg[i-1].m1;
                stg_reg[i].m2    <= stg_reg[i-1].m2;
                // product summed once in stage 1
                stg_reg[i].res   <= (i == 1 && stg_reg[i-1].op == OP_MUL) ?
                    stg_reg[i-1].m0 + {stg_reg[i-1].m1[31:0] + stg_reg[i-1].m2[31:0],
                                       32'd0} :
                    stg_reg[i-1].res;
                if (i <= DataW)
                begin
                    if (!tr[DataW])
                    begin
                        stg_reg[i].rem <= tr[DataW-1:0];
                        stg_reg[i].quo <= {stg_reg[i-1].quo[DataW-2:0], 1'b1};
                    end
                    else
                    begin
                        stg_reg[i].rem <= {stg_reg[i-1].rem[DataW-2:0],
                                           stg_reg[i-1].quo[DataW-1]};
                        stg_reg[i].quo <= {stg_reg[i-1].quo[DataW-2:0], 1'b0};
                    end
                end
                else
                begin
                    stg_reg[i].rem <= stg_reg[i-1].rem;
                    stg_reg[i].quo <= stg_reg[i-1].quo;
                end
            end
        end
    end

    // finish: sign correction and narrowing
    always_comb
    begin
        case (stg_reg[NStg-1].op)
            OP_DIV:  fin_v = stg_reg[NStg-1].neg_q ? -stg_reg[NStg-1].quo
                                                   : stg_reg[NStg-1].quo;
            OP_MOD:  fin_v = stg_reg[NStg-1].neg_r ? -stg_reg[NStg-1].rem
                                                   : stg_reg[NStg-1].rem;
            default: fin_v = stg_reg[NStg-1].res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= stg_v_reg[NStg-1];
    end

    always_ff @(posedge clk)
    begin
        logic dz_op;
        dz_op = (stg_reg[NStg-1].op == OP_DIV || stg_reg[NStg-1].op == OP_MOD) &&
                stg_reg[NStg-1].dz;
        if (adv)
        begin
            out_val_reg  <= dz_op ? '0 : narrow(fin_v, stg_reg[NStg-1].rtype);
            out_type_reg <= stg_reg[NStg-1].rtype;
            out_st_reg   <= dz_op;
        end
    end

    assign result_value = out_val_reg;
    assign result_type  = out_type_reg;
    assign status       = out_st_reg;
    assign out_valid    = out_v_reg;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result changed under stall");
    // error status only with zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> result_value == '0)
        else $error("error result not zero");
    // sign result is int64
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && stg_v_reg[NStg-1] && stg_reg[NStg-1].op == OP_SIGN
        |=> result_type == TYPE_INT64)
        else $error("sign type wrong");

endmodule

@@ hw/rtl/typed_integer_alu.sv @@
// typed_integer_alu: top level joining front, queue and back
// depends on tia_pkg, tia_front, tia_queue, tia_back
//
// usage:
//   request channel: req_type, a_value, a_type, b_value, b_type with
//   req_valid/req_ready. result channel: result_value, result_type, status
//   with res_valid/res_ready. one result per request, in order.
//   the front registers and classifies a request (narrowing, result type),
//   a small fifo decouples it from the back, which runs every operation
//   through one pipeline of 66 stages: a prep stage holding the partial
//   products, 64 restoring divide stages (one quotient bit each), and a
//   finish stage, then an output register.
//   throughput one request per cycle while the receiver does not stall.
//   reset clears all valid flags, so requests in flight are lost across
//   it. when the receiver stalls the whole back pipeline holds, the fifo
//   fills, and then req_ready drops.
module typed_integer_alu
    import tia_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [OpW-1:0]   req_type,
    input  logic [DataW-1:0] a_value,
    input  logic [TypeW-1:0] a_type,
    input  logic [DataW-1:0] b_value,
    input  logic [TypeW-1:0] b_type,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [DataW-1:0] result_value,
    output logic [TypeW-1:0] result_type,
    output logic             status
);

    tia_entry_t f_ent, q_ent;
    logic f_valid, f_ready, q_valid, q_ready;

    tia_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_type(req_type), .a_value(a_value), .a_type(a_type),
        .b_value(b_value), .b_type(b_type),
        .in_valid(req_valid), .in_ready(req_ready),
        .ent(f_ent), .ent_valid(f_valid), .ent_ready(f_ready)
    );

    tia_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(f_ent), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_ent), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    tia_back u_back (
        .clk(clk), .rst_n(rst_n),
        .ent(q_ent), .ent_valid(q_valid), .ent_ready(q_ready),
        .result_value(result_value), .result_type(result_type),
        .status(status), .out_valid(res_valid), .out_ready(res_ready)
    );

endmodule
